>>> rtl/prsa_pkg.sv
`default_nettype none

package prsa_pkg;

  // angle table: index 0 = -75 deg, 5 = 0 deg, 10 = +75 deg, 15 deg steps
  localparam int ANGLE_COUNT     = 11;
  localparam int ANGLE_TABLE_LEN = 11;
  localparam int ZERO_ANGLE_IDX  = 5;
  localparam int QUARTER_STEPS   = 6;   // 90 deg in 15 deg steps
  localparam int TABLE_FRAC      = 20;

  localparam int TRIG_FRAC_BITS_DEF = 14;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_INDEX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_SHIFT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_INVERT  = 2'd2;

  localparam logic [3:0] ROTATION_INDEX_RST = 4'd5;
  localparam logic [3:0] SCROLL_SHIFT_RST   = 4'd5;
  localparam logic       SCROLL_INVERT_RST  = 1'b1;

  // cos(k * 15 deg) in Q20, rounded half-up to frac fraction bits
  function automatic logic [16:0] trig_coef(input logic [2:0] k, input int frac);
    logic [20:0] q20;
    logic [21:0] rnd;
    int          shamt;
    case (k)
      3'd0:    q20 = 21'd1048576;
      3'd1:    q20 = 21'd1012847;
      3'd2:    q20 = 21'd908093;
      3'd3:    q20 = 21'd741455;
      3'd4:    q20 = 21'd524288;
      3'd5:    q20 = 21'd271391;
      default: q20 = 21'd0;
    endcase
    shamt = TABLE_FRAC - frac;
    rnd = {1'b0, q20} + 22'((1 << shamt) >> 1);
    trig_coef = 17'(rnd >> shamt);
  endfunction

endpackage

`default_nettype wire

>>> rtl/pointer_rotate_scroll_accumulate_unit.sv
`default_nettype none

// Channel  | Handshake              | Payload
// ---------+------------------------+------------------------------------------------
// input    | in_valid / in_stall    | in_move_x, in_move_y, in_wheel_h_in,
//          |                        | in_wheel_v_in, in_scroll_mode
// result   | out_valid / out_stall  | out_x, out_y, out_wheel_h, out_wheel_v
// config   | cfg_wr_en              | cfg_index, cfg_wdata (write only)
//
// One request per cycle sustained while out_stall is low; a taken request passes through
// the input register, the rotate stage and the scroll/result register.
// Rotation multiplies sit between input and middle registers; the accumulator
// update sits between middle and result registers.
// Synchronous active-low reset clears valids and both accumulators and loads the config reset values.
// Each stage loads when empty or when the stage after it moves, so requests are
// taken while a stalled result waits, as long as an earlier stage is free.

module pointer_rotate_scroll_accumulate_unit #(
  parameter int TRIG_FRAC_BITS = prsa_pkg::TRIG_FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,

  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [7:0]              in_move_x,
  input  wire logic signed [7:0]              in_move_y,
  input  wire logic signed [7:0]              in_wheel_h_in,
  input  wire logic signed [7:0]              in_wheel_v_in,
  input  wire logic                           in_scroll_mode,

  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [7:0]                   out_x,
  output logic signed [7:0]                   out_y,
  output logic signed [7:0]                   out_wheel_h,
  output logic signed [7:0]                   out_wheel_v,

  input  wire logic                           cfg_wr_en,
  input  wire logic [prsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [prsa_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import prsa_pkg::*;

  localparam int COEF_W = TRIG_FRAC_BITS + 2;
  localparam int SUM_W  = COEF_W + 9;

  typedef struct packed {
    logic [15:0]        acc;
    logic signed [7:0]  wheel;
  } axis_res_t;

  // configuration
  logic [3:0] rot_idx_r;
  logic [3:0] scroll_shift_r;
  logic       scroll_invert_r;

  // stage valids and flow
  logic in_v_r, mid_v_r, out_valid_r;
  logic ready_out, ready_mid, ready_in, mid_adv, in_adv;

  // input register
  logic signed [7:0] mx_r, my_r, wh_r, wv_r;
  logic              mode_r;

  // middle register
  logic signed [7:0] rx_r, ry_r, mid_wh_r, mid_wv_r;
  logic              mid_scroll_r;

  // accumulators
  logic [15:0] h_acc_r, v_acc_r;

  // result register
  logic signed [7:0] out_x_r, out_y_r, out_wh_r, out_wv_r;

  // ---------------------------------------------------------------- flow
  assign ready_out = !out_valid_r || !out_stall;
  assign mid_adv   = mid_v_r && ready_out;
  assign ready_mid = !mid_v_r || ready_out;
  assign in_adv    = in_v_r && ready_mid;
  assign ready_in  = !in_v_r || ready_mid;
  assign in_stall  = !ready_in;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_idx_r       <= ROTATION_INDEX_RST;
      scroll_shift_r  <= SCROLL_SHIFT_RST;
      scroll_invert_r <= SCROLL_INVERT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ROTATION_INDEX: rot_idx_r       <= cfg_wdata[3:0];
        CFG_SCROLL_SHIFT:   scroll_shift_r  <= cfg_wdata[3:0];
        CFG_SCROLL_INVERT:  scroll_invert_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- rotate
  logic                     idx_ok, ang_neg;
  logic [2:0]               ang_k;
  logic signed [COEF_W-1:0] c_coef, s_coef, s_mag;
  logic signed [SUM_W-1:0]  rot_x_sum, rot_y_sum;
  logic signed [7:0]        rot_x, rot_y;

  function automatic logic signed [7:0] trunc_sat(input logic signed [SUM_W-1:0] p);
    logic signed [SUM_W-1:0] q;
    logic signed [SUM_W-1:0] rnd;
    rnd = SUM_W'((1 << TRIG_FRAC_BITS) - 1);
    // toward zero: bias negative values before the arithmetic shift
    q = p[SUM_W-1] ? ((p + rnd) >>> TRIG_FRAC_BITS) : (p >>> TRIG_FRAC_BITS);
    if (q > $signed(SUM_W'(127)))
      trunc_sat = 8'sd127;
    else if (q < $signed(SUM_W'(-128)))
      trunc_sat = -8'sd128;
    else
      trunc_sat = q[7:0];
  endfunction

  always_comb begin
    idx_ok = (rot_idx_r < 4'(ANGLE_TABLE_LEN)) && ({1'b0, rot_idx_r} < 5'(ANGLE_COUNT));
    ang_neg = 1'b0;
    ang_k   = 3'd0;
    if (idx_ok) begin
      ang_neg = rot_idx_r < 4'(ZERO_ANGLE_IDX);
      ang_k   = ang_neg ? 3'(4'(ZERO_ANGLE_IDX) - rot_idx_r)
                        : 3'(rot_idx_r - 4'(ZERO_ANGLE_IDX));
    end
    c_coef = COEF_W'($signed({1'b0, trig_coef(ang_k, TRIG_FRAC_BITS)}));
    s_mag  = COEF_W'($signed({1'b0, trig_coef(3'(3'(QUARTER_STEPS) - ang_k),
                                              TRIG_FRAC_BITS)}));
    s_coef = ang_neg ? -s_mag : s_mag;
    rot_x_sum = SUM_W'(mx_r) * SUM_W'(c_coef) + SUM_W'(my_r) * SUM_W'(s_coef);
    rot_y_sum = SUM_W'(my_r) * SUM_W'(c_coef) - SUM_W'(mx_r) * SUM_W'(s_coef);
    rot_x = trunc_sat(rot_x_sum);
    rot_y = trunc_sat(rot_y_sum);
  end

  // ---------------------------------------------------------------- scroll
  function automatic axis_res_t scroll_axis(input logic [15:0] acc,
                                            input logic signed [7:0] wheel,
                                            input logic [3:0] shamt);
    logic signed [15:0] shifted;
    logic signed [7:0]  d;
    logic signed [8:0]  sum;
    logic signed [9:0]  emit;
    logic signed [15:0] emit_ext;
    axis_res_t          res;
    shifted = $signed(acc) >>> shamt;
    d = shifted[7:0];
    res.acc   = acc;
    res.wheel = wheel;
    if (d != 8'sd0) begin
      sum = 9'(wheel) + 9'(d);
      if (sum > 9'sd127)
        sum = 9'sd127;
      else if (sum < -9'sd127)
        sum = -9'sd127;
      res.wheel = sum[7:0];
      emit      = 10'(sum) - 10'(wheel);
      emit_ext  = 16'(emit);
      res.acc   = acc - 16'(emit_ext <<< shamt);
    end
    scroll_axis = res;
  endfunction

  logic signed [8:0]  sx, sy;
  logic [8:0]         abs_x, abs_y;
  logic               keep_x;
  logic signed [15:0] ext_x, ext_y;
  logic [15:0]        h_pre, v_pre;
  axis_res_t          h_res, v_res;
  logic signed [7:0]  ox_nxt, oy_nxt, oh_nxt, ov_nxt;

  always_comb begin
    sx = 9'(rx_r);
    sy = 9'(ry_r);
    abs_x = sx[8] ? 9'(-sx) : 9'(sx);
    abs_y = sy[8] ? 9'(-sy) : 9'(sy);
    // tie keeps y
    keep_x = abs_x > abs_y;
    ext_x = keep_x ? 16'(rx_r) : 16'sd0;
    ext_y = keep_x ? 16'sd0 : 16'(ry_r);
    if (scroll_invert_r) begin
      h_pre = h_acc_r + ext_x;
      v_pre = v_acc_r - ext_y;
    end else begin
      h_pre = h_acc_r - ext_x;
      v_pre = v_acc_r + ext_y;
    end
    h_res = scroll_axis(h_pre, mid_wh_r, scroll_shift_r);
    v_res = scroll_axis(v_pre, mid_wv_r, scroll_shift_r);

    if (mid_scroll_r) begin
      ox_nxt = 8'sd0;
      oy_nxt = 8'sd0;
      oh_nxt = h_res.wheel;
      ov_nxt = v_res.wheel;
    end else begin
      ox_nxt = (rx_r == -8'sd128) ? 8'sd127 : -rx_r;
      oy_nxt = ry_r;
      oh_nxt = mid_wh_r;
      ov_nxt = mid_wv_r;
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      mid_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
      h_acc_r     <= 16'd0;
      v_acc_r     <= 16'd0;
    end else begin
      if (ready_in)
        in_v_r <= in_valid;
      if (ready_mid)
        mid_v_r <= in_v_r;
      if (ready_out)
        out_valid_r <= mid_v_r;
      if (mid_adv && mid_scroll_r) begin
        h_acc_r <= h_res.acc;
        v_acc_r <= v_res.acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && ready_in) begin
      mx_r   <= in_move_x;
      my_r   <= in_move_y;
      wh_r   <= in_wheel_h_in;
      wv_r   <= in_wheel_v_in;
      mode_r <= in_scroll_mode;
    end
    if (in_adv) begin
      rx_r         <= rot_x;
      ry_r         <= rot_y;
      mid_wh_r     <= wh_r;
      mid_wv_r     <= wv_r;
      mid_scroll_r <= mode_r;
    end
    if (mid_adv) begin
      out_x_r  <= ox_nxt;
      out_y_r  <= oy_nxt;
      out_wh_r <= oh_nxt;
      out_wv_r <= ov_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_x       = out_x_r;
  assign out_y       = out_y_r;
  assign out_wheel_h = out_wh_r;
  assign out_wheel_v = out_wv_r;

`ifndef SYNTH
  a_pointer_keeps_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (mid_v_r && !mid_scroll_r) |=> ($stable(h_acc_r) && $stable(v_acc_r)))
    else $error("accumulator changed on a pointer-mode request");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_v_r && mid_v_r && out_valid_r))
    else $error("input stalled with a free stage");

  a_out_from_mid: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(mid_v_r))
    else $error("result appeared without a middle-stage request");
`endif

endmodule

`default_nettype wire

>>> dv/pointer_rotate_scroll_accumulate_checker.sv
`timescale 1ns / 100ps

module pointer_rotate_scroll_accumulate_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic signed [7:0]               in_move_x,
  input  logic signed [7:0]               in_move_y,
  input  logic signed [7:0]               in_wheel_h_in,
  input  logic signed [7:0]               in_wheel_v_in,
  input  logic                            in_scroll_mode,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic signed [7:0]               out_x,
  input  logic signed [7:0]               out_y,
  input  logic signed [7:0]               out_wheel_h,
  input  logic signed [7:0]               out_wheel_v,
  input  logic                            cfg_wr_en,
  input  logic [prsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prsa_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              pending,
  output int                              mismatches
);
  import prsa_pkg::*;

  localparam int FRAC = TRIG_FRAC_BITS_DEF;

  typedef struct packed {
    logic signed [7:0] x;
    logic signed [7:0] y;
    logic signed [7:0] wheel_h;
    logic signed [7:0] wheel_v;
  } report_t;

  report_t     wanted_q[$];
  logic [3:0]  angle_sel;
  logic [3:0]  wheel_div;
  logic        wheel_flip;
  logic [15:0] h_acc;
  logic [15:0] v_acc;
  int          err_cnt = 0;

  // cos(k * 15 deg), Q20 rounded half-up to FRAC fraction bits
  function automatic int cos_step(input int k);
    int q20;
    case (k)
      0:       q20 = 1048576;
      1:       q20 = 1012847;
      2:       q20 = 908093;
      3:       q20 = 741455;
      4:       q20 = 524288;
      5:       q20 = 271391;
      default: q20 = 0;
    endcase
    return (q20 + ((1 << (TABLE_FRAC - FRAC)) >> 1)) >> (TABLE_FRAC - FRAC);
  endfunction

  function automatic int clip8(input longint v);
    if (v > 127) return 127;
    if (v < -128) return -128;
    return int'(v);
  endfunction

  function automatic int scale_toward_zero(input longint p);
    longint m;
    m = (p < 0) ? -p : p;
    m = m >> FRAC;
    return clip8((p < 0) ? -m : m);
  endfunction

  // release whole wheel steps from an accumulator into the wheel value
  function automatic int drain_wheel(inout logic [15:0] acc, input int wheel);
    int         v;
    int         d;
    int         sum;
    logic [7:0] cut;
    v   = int'($signed(acc));
    cut = 8'(v >>> wheel_div);
    d   = int'($signed(cut));
    if (d == 0) return wheel;
    sum = wheel + d;
    if (sum > 127) sum = 127;
    else if (sum < -127) sum = -127;
    acc = acc - 16'((sum - wheel) << wheel_div);
    return sum;
  endfunction

  function automatic report_t predict_report(input int mx, input int my, input int wh,
                                             input int wv, input logic scroll);
    int      k;
    int      c;
    int      s;
    int      rx;
    int      ry;
    report_t r;
    k = 0;
    if (angle_sel < ANGLE_COUNT && angle_sel < ANGLE_TABLE_LEN) begin
      k = int'(angle_sel) - ZERO_ANGLE_IDX;
    end
    c = cos_step(k < 0 ? -k : k);
    s = cos_step(QUARTER_STEPS - (k < 0 ? -k : k));
    if (k < 0) s = -s;
    rx = scale_toward_zero(longint'(mx) * c + longint'(my) * s);
    ry = scale_toward_zero(longint'(my) * c - longint'(mx) * s);
    if (scroll) begin
      // on a tie the vertical axis wins
      if ((rx < 0 ? -rx : rx) > (ry < 0 ? -ry : ry)) ry = 0;
      else rx = 0;
      if (wheel_flip) begin
        h_acc = h_acc + 16'(rx);
        v_acc = v_acc - 16'(ry);
      end else begin
        h_acc = h_acc - 16'(rx);
        v_acc = v_acc + 16'(ry);
      end
      r.x       = '0;
      r.y       = '0;
      r.wheel_h = 8'(drain_wheel(h_acc, wh));
      r.wheel_v = 8'(drain_wheel(v_acc, wv));
    end else begin
      r.x       = 8'(clip8(-rx));
      r.y       = 8'(ry);
      r.wheel_h = 8'(wh);
      r.wheel_v = 8'(wv);
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input logic signed [7:0] exp_v,
                               input logic signed [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin : watch
    report_t want;
    if (!rst_n) begin
      angle_sel  = ROTATION_INDEX_RST;
      wheel_div  = SCROLL_SHIFT_RST;
      wheel_flip = SCROLL_INVERT_RST;
      h_acc      = '0;
      v_acc      = '0;
      wanted_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_ROTATION_INDEX: angle_sel  = cfg_wdata;
          CFG_SCROLL_SHIFT:   wheel_div  = cfg_wdata;
          CFG_SCROLL_INVERT:  wheel_flip = cfg_wdata[0];
          default: ;
        endcase
      end
      // result leaves before a new request enters; latency keeps them apart
      if (out_valid && !out_stall) begin
        if (wanted_q.size() == 0) begin
          $error("result with no request outstanding: x=%0d y=%0d h=%0d v=%0d",
                 out_x, out_y, out_wheel_h, out_wheel_v);
          err_cnt++;
        end else begin
          want = wanted_q.pop_front();
          compare_field("out_x", want.x, out_x);
          compare_field("out_y", want.y, out_y);
          compare_field("out_wheel_h", want.wheel_h, out_wheel_h);
          compare_field("out_wheel_v", want.wheel_v, out_wheel_v);
        end
      end
      if (in_valid && !in_stall) begin
        wanted_q.push_back(predict_report(in_move_x, in_move_y, in_wheel_h_in,
                                          in_wheel_v_in, in_scroll_mode));
      end
    end
    pending    <= wanted_q.size();
    mismatches <= err_cnt;
  end

endmodule

>>> dv/pointer_rotate_scroll_accumulate_unit_test.sv
`timescale 1ns / 100ps

module pointer_rotate_scroll_accumulate_unit_test;
  import prsa_pkg::*;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_stall;
  logic signed [7:0]     in_move_x      = '0;
  logic signed [7:0]     in_move_y      = '0;
  logic signed [7:0]     in_wheel_h_in  = '0;
  logic signed [7:0]     in_wheel_v_in  = '0;
  logic                  in_scroll_mode = 1'b0;
  logic                  out_valid;
  logic                  out_stall      = 1'b0;
  logic signed [7:0]     out_x;
  logic signed [7:0]     out_y;
  logic signed [7:0]     out_wheel_h;
  logic signed [7:0]     out_wheel_v;
  logic                  cfg_wr_en      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata      = '0;

  int pending;
  int mismatches;
  int send_gap_pct = 16;
  int hold_pct     = 66;
  int n_reports    = 0;
  int n_scroll     = 0;
  int n_settings   = 1;

  always #4 clk = ~clk;

  pointer_rotate_scroll_accumulate_unit u_dut (.*);

  pointer_rotate_scroll_accumulate_checker u_check (.*);

  always @(posedge clk) out_stall <= ($urandom_range(99) < hold_pct);

  task automatic send_report(input int mx, input int my, input int wh, input int wv,
                             input bit scroll);
    logic stalled;
    // each cycle the sender idles with the given odds
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_move_x      <= 8'(mx);
    in_move_y      <= 8'(my);
    in_wheel_h_in  <= 8'(wh);
    in_wheel_v_in  <= 8'(wv);
    in_scroll_mode <= scroll;
    n_reports++;
    if (scroll) n_scroll++;
    // stall is settled by the falling edge; the next rising edge takes the request
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic apply_settings(input int rot, input int shift, input int flip);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_ROTATION_INDEX;
    cfg_wdata <= 4'(rot);
    @(posedge clk);
    cfg_index <= CFG_SCROLL_SHIFT;
    cfg_wdata <= 4'(shift);
    @(posedge clk);
    cfg_index <= CFG_SCROLL_INVERT;
    cfg_wdata <= 4'(flip);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    n_settings++;
  endtask

  function automatic int pick_byte();
    case ($urandom_range(3))
      0: return int'($urandom_range(255)) - 128;
      1: return int'($urandom_range(16)) - 8;
      2: begin
        case ($urandom_range(2))
          0:       return -128;
          1:       return 127;
          default: return -127;
        endcase
      end
      default: return 0;
    endcase
  endfunction

  initial begin
    int rot_x[4]   = '{0, 10, 15, 5};
    int shift_x[4] = '{0, 15, 8, 1};
    int flip_x[4]  = '{0, 1, 0, 1};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: 0 deg, shift 5, inverted scroll
    send_report(0, 0, 0, 0, 0);
    send_report(127, 127, 127, 127, 0);
    send_report(-128, -128, -128, -128, 0);
    send_report(127, -128, -1, 1, 0);
    send_report(5, -5, 0, -128, 1);      // axis tie, v too small to emit
    send_report(127, 0, 127, 0, 1);      // h clamps at the top
    send_report(0, 127, 0, -128, 1);     // v clamps at the bottom
    send_report(0, 0, -128, 127, 1);

    apply_settings(0, 0, 0);
    send_report(127, 127, 0, 0, 0);
    send_report(-128, 127, 0, 0, 0);
    send_report(127, -128, 0, 0, 1);
    send_report(-128, -128, 127, -128, 1);
    send_report(64, -64, -128, 127, 1);

    apply_settings(10, 15, 1);
    send_report(127, 127, 0, 0, 0);
    send_report(-128, 0, 0, 0, 1);
    send_report(0, -128, 0, 0, 1);

    // angle index past the table
    apply_settings(15, 1, 0);
    send_report(100, -50, 10, -10, 0);
    send_report(-100, 50, -10, 10, 1);

    for (int p = 0; p < 13; p++) begin
      if (p < 4) begin
        send_gap_pct = 16;
        hold_pct     = 66;
        apply_settings(rot_x[p], shift_x[p], flip_x[p]);
      end else begin
        send_gap_pct = (p < 8) ? 66 : 0;
        hold_pct     = (p < 8) ? 16 : 0;
        apply_settings($urandom_range(15),
                       ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(4),
                       $urandom_range(1));
      end
      repeat (40) begin
        send_report(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                    $urandom_range(9) < 6);
      end
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (5) @(posedge clk);
    $display("Sent %0d motion reports, %0d of them in scroll mode, under %0d register settings",
             n_reports, n_scroll, n_settings);
    $display("including extreme and out-of-range angles, shift extremes, both scroll directions");
    if (mismatches == 0) begin
      $display("pointer_rotate_scroll_accumulate_unit_test OK");
    end else begin
      $display("pointer_rotate_scroll_accumulate_unit_test NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("pointer_rotate_scroll_accumulate_unit_test NOT OK");
    $finish;
  end

endmodule

>>> files.f
rtl/prsa_pkg.sv
rtl/pointer_rotate_scroll_accumulate_unit.sv
dv/pointer_rotate_scroll_accumulate_checker.sv
dv/pointer_rotate_scroll_accumulate_unit_test.sv
